// ===== rtl/cbnv_pkg.sv =====
// Shared types and constants for the cascaded biquad noise voice.
package cbnv_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int ENV_W     = 16;
  localparam int MIX_W     = 24;
  localparam int COEF_W    = 32;
  localparam int HIST_W    = 32;
  localparam int ACC_W     = 64;
  localparam int CLIP_W    = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;
  localparam int STEP_W    = 3;

  // last step of a multiply-accumulate pass: five products plus one drain add
  localparam logic [STEP_W-1:0] MAC_LAST = 3'd5;

  // operand pair fed to the shared multiplier during a section pass
  typedef enum logic [2:0] {
    TERM_FEED0,
    TERM_FEED1,
    TERM_FEED2,
    TERM_BACK1,
    TERM_BACK2
  } term_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC1,
    ST_RND1,
    ST_MAC2,
    ST_RND2,
    ST_CLIP,
    ST_GMUL,
    ST_GSCALE,
    ST_MIX
  } state_t;

  typedef struct packed {
    logic  load;       // latch input word, apply restart
    logic  mul_en;     // register a product
    logic  mul_gain;   // product is envelope times clipped output
    logic  sect;       // 0: first section, 1: second section
    term_t term;
    logic  acc_en;
    logic  acc_first;  // accumulator takes the product as is
    logic  fin_m;      // round accumulator into first section result
    logic  fin_y;      // round accumulator into second section result
    logic  clip_en;
    logic  scale_en;
    logic  mix_en;     // final add, load output word, shift histories
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/cascaded_biquad_noise_voice_core.sv =====
// Cascaded biquad noise voice: top level joining sequencer and datapath.
//
// One input word per audio sample: raw noise, envelope level, running mix
// and a restart flag that clears all filter history before the sample.
// Each word yields exactly one output word: saturated mix plus the
// filter-clip and gain-clip flags. Both channels use valid/ready.
// Coefficients are written on the cfg channel (index 0..4, 64-bit data,
// low half first section, high half second section); cfg_ready is always
// high and writes are meant to land while the block is idle.
// A single 32x32 multiplier is shared by the ten filter products and the
// envelope product, one per cycle, each section pass being a run of
// multiply-accumulate steps plus one rounding step.
// in_ready is high only when no word is in flight; a finished word waits
// in the output register, and a new word may be accepted meanwhile. If the
// previous output is still not taken when the next one is done, the
// sequencer holds at its final step until out_ready.
// Reset clears coefficients, filter history and the output valid flag.
module cascaded_biquad_noise_voice_core #(
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [cbnv_pkg::SAMPLE_W-1:0]        in_noise_raw,
  input  logic [cbnv_pkg::ENV_W-1:0]           in_envelope_level,
  input  logic signed [cbnv_pkg::MIX_W-1:0]    in_mix_in,
  input  logic                                 in_restart,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [cbnv_pkg::MIX_W-1:0]    out_mix_out,
  output logic                                 out_filter_clipped,
  output logic                                 out_gain_clipped,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cbnv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cbnv_pkg::CFG_W-1:0]           cfg_data
);

  cbnv_pkg::dp_cmd_t  cmd;
  cbnv_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  cbnv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cbnv_dp #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_noise_raw       (in_noise_raw),
    .in_envelope_level  (in_envelope_level),
    .in_mix_in          (in_mix_in),
    .in_restart         (in_restart),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_mix_out        (out_mix_out),
    .out_filter_clipped (out_filter_clipped),
    .out_gain_clipped   (out_gain_clipped)
  );

endmodule

// ===== rtl/cbnv_ctrl.sv =====
// Sequencer for the cascaded biquad noise voice datapath.
module cbnv_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cbnv_pkg::dp_stat_t stat,
  output cbnv_pkg::dp_cmd_t  cmd
);

  cbnv_pkg::state_t               state_r, state_nxt;
  logic [cbnv_pkg::STEP_W-1:0]    step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cbnv_pkg::ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      cbnv_pkg::ST_IDLE: begin
        step_nxt = '0;
        if (in_valid) state_nxt = cbnv_pkg::ST_MAC1;
      end
      cbnv_pkg::ST_MAC1: begin
        if (step_r == cbnv_pkg::MAC_LAST) begin
          step_nxt  = '0;
          state_nxt = cbnv_pkg::ST_RND1;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      cbnv_pkg::ST_RND1: state_nxt = cbnv_pkg::ST_MAC2;
      cbnv_pkg::ST_MAC2: begin
        if (step_r == cbnv_pkg::MAC_LAST) begin
          step_nxt  = '0;
          state_nxt = cbnv_pkg::ST_RND2;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      cbnv_pkg::ST_RND2:   state_nxt = cbnv_pkg::ST_CLIP;
      cbnv_pkg::ST_CLIP:   state_nxt = cbnv_pkg::ST_GMUL;
      cbnv_pkg::ST_GMUL:   state_nxt = cbnv_pkg::ST_GSCALE;
      cbnv_pkg::ST_GSCALE: state_nxt = cbnv_pkg::ST_MIX;
      cbnv_pkg::ST_MIX: begin
        if (stat.out_free) state_nxt = cbnv_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = cbnv_pkg::ST_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.term = cbnv_pkg::TERM_FEED0;
    in_ready = 1'b0;
    unique case (state_r)
      cbnv_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      cbnv_pkg::ST_MAC1, cbnv_pkg::ST_MAC2: begin
        cmd.sect      = (state_r == cbnv_pkg::ST_MAC2);
        cmd.mul_en    = (step_r != cbnv_pkg::MAC_LAST);
        cmd.acc_en    = (step_r != '0);
        cmd.acc_first = (step_r == 3'd1);
        if (step_r != cbnv_pkg::MAC_LAST) cmd.term = cbnv_pkg::term_t'(step_r);
      end
      cbnv_pkg::ST_RND1:   cmd.fin_m = 1'b1;
      cbnv_pkg::ST_RND2:   cmd.fin_y = 1'b1;
      cbnv_pkg::ST_CLIP:   cmd.clip_en = 1'b1;
      cbnv_pkg::ST_GMUL: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_gain = 1'b1;
      end
      cbnv_pkg::ST_GSCALE: cmd.scale_en = 1'b1;
      cbnv_pkg::ST_MIX:    cmd.mix_en = stat.out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/cbnv_dp.sv =====
// Datapath: coefficients, filter history, shared multiplier, accumulator and output word.
module cbnv_dp #(
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  cbnv_pkg::dp_cmd_t                    cmd,
  output cbnv_pkg::dp_stat_t                   stat,
  input  logic                                 cfg_we,
  input  logic [cbnv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cbnv_pkg::CFG_W-1:0]           cfg_data,
  input  logic [cbnv_pkg::SAMPLE_W-1:0]        in_noise_raw,
  input  logic [cbnv_pkg::ENV_W-1:0]           in_envelope_level,
  input  logic signed [cbnv_pkg::MIX_W-1:0]    in_mix_in,
  input  logic                                 in_restart,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [cbnv_pkg::MIX_W-1:0]    out_mix_out,
  output logic                                 out_filter_clipped,
  output logic                                 out_gain_clipped
);

  localparam logic [cbnv_pkg::CFG_IDX_W-1:0] CFG_FEED0 = 3'd0;
  localparam logic [cbnv_pkg::CFG_IDX_W-1:0] CFG_FEED1 = 3'd1;
  localparam logic [cbnv_pkg::CFG_IDX_W-1:0] CFG_FEED2 = 3'd2;
  localparam logic [cbnv_pkg::CFG_IDX_W-1:0] CFG_BACK1 = 3'd3;
  localparam logic [cbnv_pkg::CFG_IDX_W-1:0] CFG_BACK2 = 3'd4;

  localparam logic signed [cbnv_pkg::ACC_W-1:0] RND_HALF =
    64'sd1 <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [31:0]  UNITY32 = 32'sd32768;
  localparam logic signed [33:0]  UNITY34 = 34'sd32768;
  localparam logic signed [cbnv_pkg::CLIP_W-1:0] UNITY17 = 17'sd32768;
  localparam logic signed [cbnv_pkg::MIX_W:0] MIX_MAX = 25'sd8388607;
  localparam logic signed [cbnv_pkg::MIX_W:0] MIX_MIN = -25'sd8388608;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_add = s[63:0];
    end
  endfunction

  logic [cbnv_pkg::CFG_W-1:0] feed0_r, feed1_r, feed2_r, back1_r, back2_r;

  logic signed [cbnv_pkg::SAMPLE_W-1:0] x_r, xh1_r, xh2_r;
  logic signed [cbnv_pkg::HIST_W-1:0]   mh1_r, mh2_r, yh1_r, yh2_r;
  logic [cbnv_pkg::ENV_W-1:0]           env_r;
  logic signed [cbnv_pkg::MIX_W-1:0]    mix_r;

  logic signed [cbnv_pkg::ACC_W-1:0]    prod_r, acc_r;
  logic signed [cbnv_pkg::HIST_W-1:0]   m_r, y_r;
  logic signed [cbnv_pkg::CLIP_W-1:0]   yc_r, g_r;
  logic                                 fclip_r, gclip_r;

  logic                                 out_valid_r;
  logic signed [cbnv_pkg::MIX_W-1:0]    out_mix_r;
  logic                                 out_fclip_r, out_gclip_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feed0_r <= '0;
      feed1_r <= '0;
      feed2_r <= '0;
      back1_r <= '0;
      back2_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FEED0: feed0_r <= cfg_data;
        CFG_FEED1: feed1_r <= cfg_data;
        CFG_FEED2: feed2_r <= cfg_data;
        CFG_BACK1: back1_r <= cfg_data;
        CFG_BACK2: back2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // operand selection for the shared multiplier
  logic [cbnv_pkg::CFG_W-1:0]           coef_pair;
  logic signed [cbnv_pkg::COEF_W-1:0]   op_a, op_b;
  logic signed [cbnv_pkg::ACC_W-1:0]    prod_c;

  always_comb begin
    coef_pair = feed0_r;
    op_b      = '0;
    unique case (cmd.term)
      cbnv_pkg::TERM_FEED0: begin
        coef_pair = feed0_r;
        op_b = cmd.sect ? m_r : 32'(x_r);
      end
      cbnv_pkg::TERM_FEED1: begin
        coef_pair = feed1_r;
        op_b = cmd.sect ? mh1_r : 32'(xh1_r);
      end
      cbnv_pkg::TERM_FEED2: begin
        coef_pair = feed2_r;
        op_b = cmd.sect ? mh2_r : 32'(xh2_r);
      end
      cbnv_pkg::TERM_BACK1: begin
        coef_pair = back1_r;
        op_b = cmd.sect ? yh1_r : mh1_r;
      end
      cbnv_pkg::TERM_BACK2: begin
        coef_pair = back2_r;
        op_b = cmd.sect ? yh2_r : mh2_r;
      end
      default: ;
    endcase
    op_a = cmd.sect ? $signed(coef_pair[63:32]) : $signed(coef_pair[31:0]);
    if (cmd.mul_gain) begin
      op_a = $signed({16'd0, env_r});
      op_b = 32'(yc_r);
    end
  end

  assign prod_c = op_a * op_b;

  // rounding of the accumulator back to a 32-bit sample
  logic signed [cbnv_pkg::ACC_W-1:0]  acc_rnd, acc_shf;
  logic signed [cbnv_pkg::HIST_W-1:0] rnd_res;

  always_comb begin
    acc_rnd = sat_add(acc_r, RND_HALF);
    acc_shf = acc_rnd >>> COEF_FRAC_BITS;
    if (acc_shf[63:31] != {33{acc_shf[63]}}) begin
      rnd_res = acc_shf[63] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end else begin
      rnd_res = acc_shf[31:0];
    end
  end

  // envelope scaling: product fits in 33 bits
  logic signed [33:0] gp_rnd, gp_shf;
  assign gp_rnd = prod_r[33:0] + 34'sd128;
  assign gp_shf = gp_rnd >>> 8;

  logic signed [cbnv_pkg::MIX_W:0] mix_sum;
  assign mix_sum = {mix_r[cbnv_pkg::MIX_W-1], mix_r} + (cbnv_pkg::MIX_W+1)'(g_r);

  // filter history: cleared on a restart load, shifted at the final add
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xh1_r <= '0;
      xh2_r <= '0;
      mh1_r <= '0;
      mh2_r <= '0;
      yh1_r <= '0;
      yh2_r <= '0;
    end else if (cmd.load && in_restart) begin
      xh1_r <= '0;
      xh2_r <= '0;
      mh1_r <= '0;
      mh2_r <= '0;
      yh1_r <= '0;
      yh2_r <= '0;
    end else if (cmd.mix_en) begin
      xh2_r <= xh1_r;
      xh1_r <= x_r;
      mh2_r <= mh1_r;
      mh1_r <= m_r;
      yh2_r <= yh1_r;
      yh1_r <= y_r;
    end
  end

  // datapath payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      // raw word minus half scale: flip the top bit
      x_r   <= $signed({~in_noise_raw[15], in_noise_raw[14:0]});
      env_r <= in_envelope_level;
      mix_r <= in_mix_in;
    end
    if (cmd.mul_en) prod_r <= prod_c;
    if (cmd.acc_en) acc_r <= cmd.acc_first ? prod_r : sat_add(acc_r, prod_r);
    if (cmd.fin_m) m_r <= rnd_res;
    if (cmd.fin_y) y_r <= rnd_res;
    if (cmd.clip_en) begin
      if (y_r > UNITY32) begin
        yc_r    <= UNITY17;
        fclip_r <= 1'b1;
      end else if (y_r < -UNITY32) begin
        yc_r    <= -UNITY17;
        fclip_r <= 1'b1;
      end else begin
        yc_r    <= y_r[cbnv_pkg::CLIP_W-1:0];
        fclip_r <= 1'b0;
      end
    end
    if (cmd.scale_en) begin
      if (gp_shf > UNITY34) begin
        g_r     <= UNITY17;
        gclip_r <= 1'b1;
      end else if (gp_shf < -UNITY34) begin
        g_r     <= -UNITY17;
        gclip_r <= 1'b1;
      end else begin
        g_r     <= gp_shf[cbnv_pkg::CLIP_W-1:0];
        gclip_r <= 1'b0;
      end
    end
    if (cmd.mix_en) begin
      if (mix_sum > MIX_MAX) begin
        out_mix_r <= MIX_MAX[cbnv_pkg::MIX_W-1:0];
      end else if (mix_sum < MIX_MIN) begin
        out_mix_r <= MIX_MIN[cbnv_pkg::MIX_W-1:0];
      end else begin
        out_mix_r <= mix_sum[cbnv_pkg::MIX_W-1:0];
      end
      out_fclip_r <= fclip_r;
      out_gclip_r <= gclip_r;
    end
  end

  // output word holding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.mix_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.out_free      = !out_valid_r || out_ready;
  assign out_valid          = out_valid_r;
  assign out_mix_out        = out_mix_r;
  assign out_filter_clipped = out_fclip_r;
  assign out_gain_clipped   = out_gclip_r;

endmodule

// ===== verif/cascaded_biquad_noise_voice_core_tb.sv =====
// Testbench for the cascaded biquad noise voice core: directed table, random words, self-checking.
module cascaded_biquad_noise_voice_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS   = 28;
  localparam int UNITY       = 32768;
  localparam int WATCHDOG    = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 30;
  localparam int RAND_PHASES = 9;
  localparam int PHASE_WORDS = 100;

  localparam logic [cbnv_pkg::CFG_IDX_W-1:0] REG_FEED0 = 3'd0;
  localparam logic [cbnv_pkg::CFG_IDX_W-1:0] REG_FEED1 = 3'd1;
  localparam logic [cbnv_pkg::CFG_IDX_W-1:0] REG_FEED2 = 3'd2;
  localparam logic [cbnv_pkg::CFG_IDX_W-1:0] REG_BACK1 = 3'd3;
  localparam logic [cbnv_pkg::CFG_IDX_W-1:0] REG_BACK2 = 3'd4;

  localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint ACC_MIN = -64'sh7FFF_FFFF_FFFF_FFFF - 64'sd1;
  localparam longint MIX_MAX = 64'sd8388607;
  localparam longint MIX_MIN = -64'sd8388608;

  typedef struct packed {
    logic [cbnv_pkg::SAMPLE_W-1:0]     noise;
    logic [cbnv_pkg::ENV_W-1:0]        env;
    logic signed [cbnv_pkg::MIX_W-1:0] mix;
    logic                              restart;
  } voice_word_t;

  typedef struct packed {
    logic signed [cbnv_pkg::MIX_W-1:0] mix;
    logic                              filter_clip;
    logic                              gain_clip;
  } voice_result_t;

  typedef struct packed {
    logic [cbnv_pkg::CFG_W-1:0] feed0;
    logic [cbnv_pkg::CFG_W-1:0] feed1;
    logic [cbnv_pkg::CFG_W-1:0] feed2;
    logic [cbnv_pkg::CFG_W-1:0] back1;
    logic [cbnv_pkg::CFG_W-1:0] back2;
  } coef_bank_t;

  typedef struct {
    int            cset;
    voice_word_t   w;
    bit            typed;
    voice_result_t res;
  } plan_row_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [cbnv_pkg::SAMPLE_W-1:0]     in_noise_raw = '0;
  logic [cbnv_pkg::ENV_W-1:0]        in_envelope_level = '0;
  logic signed [cbnv_pkg::MIX_W-1:0] in_mix_in = '0;
  logic                              in_restart = 1'b0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic signed [cbnv_pkg::MIX_W-1:0] out_mix_out;
  logic                              out_filter_clipped;
  logic                              out_gain_clipped;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [cbnv_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [cbnv_pkg::CFG_W-1:0]        cfg_data = '0;

  cascaded_biquad_noise_voice_core #(
    .COEF_FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_noise_raw       (in_noise_raw),
    .in_envelope_level  (in_envelope_level),
    .in_mix_in          (in_mix_in),
    .in_restart         (in_restart),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_mix_out        (out_mix_out),
    .out_filter_clipped (out_filter_clipped),
    .out_gain_clipped   (out_gain_clipped),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #5 clk = ~clk;

  // predictor copy of coefficients and filter history
  coef_bank_t          bank = '0;
  logic signed [15:0]  hist_x1 = '0, hist_x2 = '0;
  logic signed [31:0]  hist_m1 = '0, hist_m2 = '0;
  logic signed [31:0]  hist_y1 = '0, hist_y2 = '0;

  voice_result_t voice_due[$];
  plan_row_t     plan[$];
  coef_bank_t    coef_sets[5];

  int mismatch_count = 0;
  int tx_idle_pct = 20;
  int rx_idle_pct = 20;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int stall_cycles = 0;

  function automatic longint sat_add64(longint a, longint b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) + $signed({b[63], b});
    if (s > ACC_MAX) return ACC_MAX;
    if (s < ACC_MIN) return ACC_MIN;
    return longint'(s[63:0]);
  endfunction

  function automatic int coef_half(logic [cbnv_pkg::CFG_W-1:0] c, bit hi);
    return hi ? int'(c[63:32]) : int'(c[31:0]);
  endfunction

  function automatic int section_pass(bit hi, int in0, int in1, int in2, int fb1, int fb2);
    longint acc;
    acc = longint'(coef_half(bank.feed0, hi)) * longint'(in0);
    acc = sat_add64(acc, longint'(coef_half(bank.feed1, hi)) * longint'(in1));
    acc = sat_add64(acc, longint'(coef_half(bank.feed2, hi)) * longint'(in2));
    acc = sat_add64(acc, longint'(coef_half(bank.back1, hi)) * longint'(fb1));
    acc = sat_add64(acc, longint'(coef_half(bank.back2, hi)) * longint'(fb2));
    acc = sat_add64(acc, longint'(1) <<< (FRAC_BITS - 1));
    acc = acc >>> FRAC_BITS;
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return int'(acc);
  endfunction

  function automatic voice_result_t predict_voice(voice_word_t w);
    int            x, m, y;
    longint        g, sum;
    voice_result_t r;
    r = '0;
    x = int'(w.noise) - UNITY;
    if (w.restart) begin
      hist_x1 = '0; hist_x2 = '0;
      hist_m1 = '0; hist_m2 = '0;
      hist_y1 = '0; hist_y2 = '0;
    end
    m = section_pass(1'b0, x, hist_x1, hist_x2, hist_m1, hist_m2);
    y = section_pass(1'b1, m, hist_m1, hist_m2, hist_y1, hist_y2);
    hist_x2 = hist_x1;
    hist_x1 = x[15:0];
    hist_m2 = hist_m1;
    hist_m1 = m;
    hist_y2 = hist_y1;
    hist_y1 = y;
    // history keeps the unclipped y
    if (y > UNITY) begin
      y = UNITY; r.filter_clip = 1'b1;
    end else if (y < -UNITY) begin
      y = -UNITY; r.filter_clip = 1'b1;
    end
    g = (longint'(w.env) * longint'(y) + 64'sd128) >>> 8;
    if (g > UNITY) begin
      g = UNITY; r.gain_clip = 1'b1;
    end else if (g < -UNITY) begin
      g = -UNITY; r.gain_clip = 1'b1;
    end
    sum = longint'(w.mix) + g;
    if (sum > MIX_MAX) sum = MIX_MAX;
    if (sum < MIX_MIN) sum = MIX_MIN;
    r.mix = sum[cbnv_pkg::MIX_W-1:0];
    return r;
  endfunction

  function automatic void add_row(int cset, logic [15:0] noise, logic [15:0] env,
                                  logic [23:0] mix, bit restart, bit typed,
                                  logic [23:0] exp_mix);
    plan_row_t row;
    row.cset = cset;
    row.w = '{noise: noise, env: env, mix: mix, restart: restart};
    row.typed = typed;
    row.res = '{mix: exp_mix, filter_clip: 1'b0, gain_clip: 1'b0};
    plan.push_back(row);
  endfunction

  function automatic logic [31:0] bounded_coef(int span_log2);
    return 32'($urandom_range(0, 32'd1 << (span_log2 + 1))) - (32'd1 << span_log2);
  endfunction

  function automatic coef_bank_t random_bank(bit full);
    coef_bank_t b;
    if (full) begin
      b.feed0 = {$urandom, $urandom};
      b.feed1 = {$urandom, $urandom};
      b.feed2 = {$urandom, $urandom};
      b.back1 = {$urandom, $urandom};
      b.back2 = {$urandom, $urandom};
    end else begin
      // feed weights within +-1.0, feedback within +-0.25 each: bounded response
      b.feed0 = {bounded_coef(28), bounded_coef(28)};
      b.feed1 = {bounded_coef(28), bounded_coef(28)};
      b.feed2 = {bounded_coef(28), bounded_coef(28)};
      b.back1 = {bounded_coef(26), bounded_coef(26)};
      b.back2 = {bounded_coef(26), bounded_coef(26)};
    end
    return b;
  endfunction

  function automatic voice_word_t random_word();
    voice_word_t w;
    w.noise = 16'($urandom);
    w.env = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16'h0200));
    case ($urandom_range(9))
      0: w.mix = 24'h7FFFFF - 24'($urandom_range(0, 40000));
      1: w.mix = 24'h800000 + 24'($urandom_range(0, 40000));
      default: w.mix = 24'($urandom);
    endcase
    w.restart = ($urandom_range(15) == 0);
    return w;
  endfunction

  task automatic write_reg(logic [cbnv_pkg::CFG_IDX_W-1:0] idx,
                           logic [cbnv_pkg::CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_FEED0: bank.feed0 = data;
      REG_FEED1: bank.feed1 = data;
      REG_FEED2: bank.feed2 = data;
      REG_BACK1: bank.back1 = data;
      REG_BACK2: bank.back2 = data;
      default: ;
    endcase
  endtask

  task automatic program_filter(coef_bank_t b);
    write_reg(REG_FEED0, b.feed0);
    write_reg(REG_FEED1, b.feed1);
    write_reg(REG_FEED2, b.feed2);
    write_reg(REG_BACK1, b.back1);
    write_reg(REG_BACK2, b.back2);
    cfg_valid <= 1'b0;
  endtask

  task automatic offer_word(voice_word_t w, bit typed, voice_result_t typed_res);
    int            gap;
    voice_result_t r;
    gap = 0;
    if ($urandom_range(99) < tx_idle_pct) gap = $urandom_range(1, 24);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_noise_raw      <= w.noise;
    in_envelope_level <= w.env;
    in_mix_in         <= w.mix;
    in_restart        <= w.restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = predict_voice(w);
    voice_due.push_back(typed ? typed_res : r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (voice_due.size() != 0) @(posedge clk);
  endtask

  // receiver: random back-pressure plus a long hold on request
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    voice_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (voice_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("mismatch: output word with none expected: mix %0d fclip %0b gclip %0b",
                   out_mix_out, out_filter_clipped, out_gain_clipped);
      end else begin
        exp_r = voice_due.pop_front();
        if (out_mix_out !== exp_r.mix || out_filter_clipped !== exp_r.filter_clip ||
            out_gain_clipped !== exp_r.gain_clip) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp mix %0d fc %0b gc %0b, got mix %0d fc %0b gc %0b",
                     exp_r.mix, exp_r.filter_clip, exp_r.gain_clip,
                     out_mix_out, out_filter_clipped, out_gain_clipped);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int         cur_set;
    int         ph;
    int         n;
    coef_bank_t b;

    coef_sets[0] = '0;
    // unity pass-through in both sections
    b = '0;
    b.feed0 = {32'h1000_0000, 32'h1000_0000};
    coef_sets[1] = b;
    // largest positive gain: forces filter clip
    b = '0;
    b.feed0 = {32'h7FFF_FFFF, 32'h7FFF_FFFF};
    coef_sets[2] = b;
    // all weights most negative: history runs away into both saturations
    coef_sets[3] = {5{64'h8000_0000_8000_0000}};
    // all ones: smallest negative weights, exercises rounding
    coef_sets[4] = {5{64'hFFFF_FFFF_FFFF_FFFF}};

    // zero coefficients: the mix passes through unchanged
    add_row(0, 16'h0000, 16'h0000, 24'h000000, 1'b0, 1'b1, 24'h000000);
    add_row(0, 16'hFFFF, 16'hFFFF, 24'h7FFFFF, 1'b1, 1'b1, 24'h7FFFFF);
    add_row(0, 16'h8000, 16'hFFFF, 24'h800000, 1'b0, 1'b1, 24'h800000);
    add_row(0, 16'h0000, 16'h0100, 24'h123456, 1'b0, 1'b1, 24'h123456);
    add_row(1, 16'h0000, 16'h0100, 24'h000000, 1'b1, 1'b0, '0);
    add_row(1, 16'hFFFF, 16'h0100, 24'h7FFFFF, 1'b0, 1'b0, '0);
    add_row(1, 16'h0000, 16'hFFFF, 24'h800000, 1'b0, 1'b0, '0);
    add_row(1, 16'hFFFF, 16'hFFFF, 24'h000000, 1'b0, 1'b0, '0);
    add_row(1, 16'h8000, 16'hFFFF, 24'h000000, 1'b0, 1'b0, '0);
    add_row(1, 16'h8001, 16'h0080, 24'h000000, 1'b0, 1'b0, '0);
    add_row(1, 16'h7FFF, 16'h0080, 24'h000000, 1'b0, 1'b0, '0);
    add_row(2, 16'hFFFF, 16'h0100, 24'h000000, 1'b1, 1'b0, '0);
    add_row(2, 16'h0000, 16'h0040, 24'h000000, 1'b0, 1'b0, '0);
    add_row(2, 16'h8000, 16'h0100, 24'h7FFF00, 1'b0, 1'b0, '0);
    add_row(3, 16'h0000, 16'h0100, 24'h000000, 1'b1, 1'b0, '0);
    add_row(3, 16'h0000, 16'h0100, 24'h000000, 1'b0, 1'b0, '0);
    add_row(3, 16'h0000, 16'hFFFF, 24'h400000, 1'b0, 1'b0, '0);
    add_row(3, 16'h0000, 16'h0001, 24'hC00000, 1'b0, 1'b0, '0);
    add_row(3, 16'h0000, 16'h0100, 24'h000000, 1'b0, 1'b0, '0);
    add_row(3, 16'hFFFF, 16'h0100, 24'h000000, 1'b1, 1'b0, '0);
    add_row(4, 16'hFFFF, 16'hFFFF, 24'h000000, 1'b1, 1'b0, '0);
    add_row(4, 16'h0000, 16'h0001, 24'h400000, 1'b0, 1'b0, '0);
    add_row(4, 16'h1234, 16'h0180, 24'hABCDEF, 1'b0, 1'b0, '0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    cur_set = -1;
    foreach (plan[i]) begin
      if (plan[i].cset != cur_set) begin
        drain();
        program_filter(coef_sets[plan[i].cset]);
        cur_set = plan[i].cset;
      end
      offer_word(plan[i].w, plan[i].typed, plan[i].res);
    end

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      tx_idle_pct = (ph < 3) ? 32 : (ph < 6) ? 58 : 0;
      rx_idle_pct <= (ph < 3) ? 58 : (ph < 6) ? 32 : 0;
      program_filter(random_bank(ph % 3 == 1));
      for (n = 0; n < PHASE_WORDS; n++) begin
        // long receiver hold while words keep coming: input stalls
        if ((ph == 1 || ph == 7) && n == 30) hold_req <= hold_req + 1;
        offer_word(random_word(), 1'b0, '0);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && voice_due.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
